>>> rtl/sirt_pkg.sv
`timescale 1ns / 1ps
package sirt_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_RADIX  = 32;
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 5;
    localparam int MAX_DIGITS = 32;
    localparam int DPTR_W     = 5;
    localparam int CH_W       = 8;
    localparam int RECIP_W    = 32;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    localparam logic [CH_W-1:0] MINUS_CHAR = 8'h2D;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_0_7   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_8_15  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_16_23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_24_31 = 3'd4;

    localparam logic [63:0] TWO_POW_32 = 64'h1_0000_0000;

    // one classified number waiting for conversion
    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } item_t;

    typedef logic [MAX_DIGITS-1:0][CH_W-1:0] alphabet_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_SIGN,
        B_EMIT
    } back_state_t;

    // floor(2^32 / r); the quotient estimate from it is low by at most one
    function automatic logic [RECIP_W-1:0] recip_of(input logic [RADIX_W-1:0] r);
        case (r)
            6'd3:  recip_of = 32'(TWO_POW_32 / 64'd3);
            6'd4:  recip_of = 32'(TWO_POW_32 / 64'd4);
            6'd5:  recip_of = 32'(TWO_POW_32 / 64'd5);
            6'd6:  recip_of = 32'(TWO_POW_32 / 64'd6);
            6'd7:  recip_of = 32'(TWO_POW_32 / 64'd7);
            6'd8:  recip_of = 32'(TWO_POW_32 / 64'd8);
            6'd9:  recip_of = 32'(TWO_POW_32 / 64'd9);
            6'd10: recip_of = 32'(TWO_POW_32 / 64'd10);
            6'd11: recip_of = 32'(TWO_POW_32 / 64'd11);
            6'd12: recip_of = 32'(TWO_POW_32 / 64'd12);
            6'd13: recip_of = 32'(TWO_POW_32 / 64'd13);
            6'd14: recip_of = 32'(TWO_POW_32 / 64'd14);
            6'd15: recip_of = 32'(TWO_POW_32 / 64'd15);
            6'd16: recip_of = 32'(TWO_POW_32 / 64'd16);
            6'd17: recip_of = 32'(TWO_POW_32 / 64'd17);
            6'd18: recip_of = 32'(TWO_POW_32 / 64'd18);
            6'd19: recip_of = 32'(TWO_POW_32 / 64'd19);
            6'd20: recip_of = 32'(TWO_POW_32 / 64'd20);
            6'd21: recip_of = 32'(TWO_POW_32 / 64'd21);
            6'd22: recip_of = 32'(TWO_POW_32 / 64'd22);
            6'd23: recip_of = 32'(TWO_POW_32 / 64'd23);
            6'd24: recip_of = 32'(TWO_POW_32 / 64'd24);
            6'd25: recip_of = 32'(TWO_POW_32 / 64'd25);
            6'd26: recip_of = 32'(TWO_POW_32 / 64'd26);
            6'd27: recip_of = 32'(TWO_POW_32 / 64'd27);
            6'd28: recip_of = 32'(TWO_POW_32 / 64'd28);
            6'd29: recip_of = 32'(TWO_POW_32 / 64'd29);
            6'd30: recip_of = 32'(TWO_POW_32 / 64'd30);
            6'd31: recip_of = 32'(TWO_POW_32 / 64'd31);
            6'd32: recip_of = 32'(TWO_POW_32 / 64'd32);
            default: recip_of = 32'(TWO_POW_32 / 64'd2);
        endcase
    endfunction

endpackage

>>> rtl/sirt_front.sv
`timescale 1ns / 1ps
module sirt_front
    import sirt_pkg::*;
(
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic signed [VALUE_BITS-1:0] s_tdata,  // value
    input  logic                         q_full,
    output logic                         q_push,
    output item_t                        q_item
);

    logic [VALUE_BITS-1:0] raw;

    assign raw      = VALUE_BITS'(s_tdata);
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // magnitude of the most negative value still fits unsigned
    always_comb begin
        q_item.neg = raw[VALUE_BITS-1];
        q_item.mag = raw[VALUE_BITS-1] ? VALUE_BITS'(~raw + 1'b1) : raw;
    end

endmodule

>>> rtl/sirt_queue.sv
`timescale 1ns / 1ps
module sirt_queue
    import sirt_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = entry_reg[rptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/sirt_back.sv
`timescale 1ns / 1ps
module sirt_back
    import sirt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [RADIX_W-1:0] radix,
    input  alphabet_t          alphabet,
    input  logic               q_empty,
    input  item_t              q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CH_W-1:0]    m_tdata,  // ch
    output logic               m_tlast
);

    back_state_t state_reg;
    back_state_t state_next;

    logic [VALUE_BITS-1:0]   mag_reg;
    logic                    neg_reg;
    logic [RADIX_W-1:0]      div_reg;
    logic [RECIP_W-1:0]      recip_reg;
    logic [2*VALUE_BITS-1:0] prod_reg;
    logic [DPTR_W-1:0]       wptr_reg;
    logic [DPTR_W-1:0]       rptr_reg;
    logic [DIGIT_W-1:0]      digit_mem [MAX_DIGITS];

    logic              m_tvalid_reg;
    logic [CH_W-1:0]   ch_reg;
    logic              last_reg;

    logic [RADIX_W-1:0] eff_radix;

    logic [VALUE_BITS-1:0]         q_est;
    logic [VALUE_BITS+RADIX_W-1:0] qd;
    logic [VALUE_BITS+RADIX_W-1:0] rem_wide;
    logic [RADIX_W:0]              rem;
    logic [VALUE_BITS-1:0]         q_fix;
    logic [DIGIT_W-1:0]            digit;
    logic                          div_done;

    logic              out_free;
    logic              load_item;
    logic              mul_en;
    logic              div_en;
    logic              out_load;
    logic [CH_W-1:0]   ch_next;
    logic              last_next;

    always_comb begin
        if (radix < RADIX_W'(2)) begin
            eff_radix = RADIX_W'(2);
        end else if (radix > RADIX_W'(MAX_RADIX)) begin
            eff_radix = RADIX_W'(MAX_RADIX);
        end else begin
            eff_radix = radix;
        end
    end

    // quotient estimate, then one correction step
    always_comb begin
        q_est    = prod_reg[2*VALUE_BITS-1:VALUE_BITS];
        qd       = (VALUE_BITS+RADIX_W)'(q_est) * (VALUE_BITS+RADIX_W)'(div_reg);
        rem_wide = (VALUE_BITS+RADIX_W)'(mag_reg) - qd;
        rem      = rem_wide[RADIX_W:0];
        if (rem >= {1'b0, div_reg}) begin
            q_fix = q_est + 1'b1;
            digit = DIGIT_W'(rem - {1'b0, div_reg});
        end else begin
            q_fix = q_est;
            digit = rem[DIGIT_W-1:0];
        end
        div_done = (q_fix == '0) || (wptr_reg == DPTR_W'(MAX_DIGITS - 1));
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    state_next = B_MUL;
                end
            end
            B_MUL: begin
                state_next = B_DIV;
            end
            B_DIV: begin
                if (div_done) begin
                    state_next = neg_reg ? B_SIGN : B_EMIT;
                end else begin
                    state_next = B_MUL;
                end
            end
            B_SIGN: begin
                if (out_free) begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT: begin
                if (out_free && (rptr_reg == '0)) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb begin
        load_item = 1'b0;
        mul_en    = 1'b0;
        div_en    = 1'b0;
        out_load  = 1'b0;
        ch_next   = MINUS_CHAR;
        last_next = 1'b0;
        case (state_reg)
            B_IDLE: begin
                load_item = !q_empty;
            end
            B_MUL: begin
                mul_en = 1'b1;
            end
            B_DIV: begin
                div_en = 1'b1;
            end
            B_SIGN: begin
                out_load = out_free;
            end
            B_EMIT: begin
                out_load  = out_free;
                ch_next   = alphabet[digit_mem[rptr_reg]];
                last_next = (rptr_reg == '0);
            end
            default: begin
                load_item = 1'b0;
            end
        endcase
    end

    assign q_pop = load_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_item) begin
                wptr_reg <= '0;
            end else if (div_en) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (div_en) begin
                rptr_reg <= wptr_reg;
            end else if (out_load && (state_reg == B_EMIT)) begin
                rptr_reg <= rptr_reg - 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_item) begin
            mag_reg   <= q_item.mag;
            neg_reg   <= q_item.neg;
            div_reg   <= eff_radix;
            recip_reg <= recip_of(eff_radix);
        end else if (div_en) begin
            mag_reg <= q_fix;
        end
        if (mul_en) begin
            prod_reg <= (2*VALUE_BITS)'(mag_reg) * (2*VALUE_BITS)'(recip_reg);
        end
        if (div_en) begin
            digit_mem[wptr_reg] <= digit;
        end
        if (out_load) begin
            ch_reg   <= ch_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ch_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/signed_int_to_radix_text_unit.sv
`timescale 1ns / 1ps
// Converts each signed 32-bit value into its text in the configured radix and sends
// it out one character per transfer, most significant digit first, with a leading
// minus sign for negative values (the most negative value converts correctly) and
// m_tlast on the final digit; zero gives a single digit-0 symbol. The radix register
// is clamped to 2..32, and digit d is sent as byte d of the 32-byte alphabet held in
// the four symbol registers (all zero after reset). For each digit the divider first
// does a 32x32 multiply by the stored reciprocal of the radix, then a back-multiply
// with one correction step. Characters are then read out of the digit buffer one per
// cycle into the output register, as long as it is free. A two-entry queue sits
// between the input classifier and the converter, so up to two further values are
// taken while one is converted. The output register holds a character until it is
// taken; while it waits the read-out stalls. Configuration must be written only while
// the unit is idle; the unit itself does not enforce this.
module signed_int_to_radix_text_unit
    import sirt_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write port
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_addr,
    input  logic [CFG_W-1:0]             cfg_wdata,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic signed [VALUE_BITS-1:0] s_tdata,   // [31:0] value
    // character stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [CH_W-1:0]              m_tdata,   // [7:0] ch
    output logic                         m_tlast
);

    logic [RADIX_W-1:0] radix_reg;
    logic [CFG_W-1:0]   sym0_reg;
    logic [CFG_W-1:0]   sym1_reg;
    logic [CFG_W-1:0]   sym2_reg;
    logic [CFG_W-1:0]   sym3_reg;
    alphabet_t          alphabet;

    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    item_t push_item;
    item_t pop_item;

    // configuration registers; writes to unused indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_W'(10);
            sym0_reg  <= '0;
            sym1_reg  <= '0;
            sym2_reg  <= '0;
            sym3_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_RADIX:     radix_reg <= cfg_wdata[RADIX_W-1:0];
                CFG_SYM_0_7:   sym0_reg  <= cfg_wdata;
                CFG_SYM_8_15:  sym1_reg  <= cfg_wdata;
                CFG_SYM_16_23: sym2_reg  <= cfg_wdata;
                CFG_SYM_24_31: sym3_reg  <= cfg_wdata;
                default: begin
                    radix_reg <= radix_reg;
                end
            endcase
        end
    end

    // byte i of the concatenation is the symbol for digit i
    assign alphabet = alphabet_t'({sym3_reg, sym2_reg, sym1_reg, sym0_reg});

    // front: sign/magnitude split and queue write
    sirt_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    sirt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    // back: digit extraction and character output
    sirt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .radix    (radix_reg),
        .alphabet (alphabet),
        .q_empty  (q_empty),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
